// ----- sv/pca_pkg.sv -----
// ----------------------------------------------------------------------------
// pca_pkg
// Shared constants, codes and channel payload types of the per-cpu page
// allocator.
// ----------------------------------------------------------------------------
package pca_pkg;

  // sizing of the allocator (PAGE_BYTES must be a power of two)
  localparam int unsigned CPU_COUNT  = 8;
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned PAGE_COUNT = 32768;

  // fixed field widths
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned CPU_W     = 3;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // derived widths
  localparam int unsigned CPU_IDX_W  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int unsigned SLOT_W     = $clog2(PAGE_COUNT);
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  // page number of the rounded-up base, one extra bit for the round-up carry
  localparam int unsigned PNUM_W     = ADDR_W - PAGE_SHIFT + 1;
  // shared adder: byte addresses plus a borrow bit
  localparam int unsigned ALU_W      = ADDR_W + 1;

  // register reset values
  localparam logic [ADDR_W-1:0] REGION_START_RST = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] REGION_STOP_RST  = 32'h8800_0000;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC  = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FREED  = 2'd2,
    ST_REJECT = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REGION_START = 1'b0,
    REG_REGION_STOP  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic              operation;
    logic [CPU_W-1:0]  cpu;
    logic [ADDR_W-1:0] addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   page_addr;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    data;
  } cfg_t;

endpackage

// ----- sv/pca_if.sv -----
// ----------------------------------------------------------------------------
// pca_if
// Valid/ready channels of the per-cpu page allocator: request, response
// and configuration write.
// ----------------------------------------------------------------------------
interface pca_req_if;
  import pca_pkg::*;

  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pca_rsp_if;
  import pca_pkg::*;

  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pca_cfg_if;
  import pca_pkg::*;

  logic valid;
  logic ready;
  cfg_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/pca_ram.sv -----
// ----------------------------------------------------------------------------
// pca_ram
// Generic single-port RAM, one read or write per cycle, registered read.
// ----------------------------------------------------------------------------
module pca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write or registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/per_cpu_page_allocator_core.sv -----
// ----------------------------------------------------------------------------
// per_cpu_page_allocator_core
// Physical page allocator with one LIFO free list per cpu. Allocations pop
// the own list or steal from the next non-empty list going round; frees are
// range checked and pushed onto the own list.
// ----------------------------------------------------------------------------
//
//  channel  dir  transaction            payload
//  req_i    in   allocate or free       operation, cpu, addr
//  rsp_o    out  one result per request page_addr, status
//  cfg_i    in   register write         index, data (always ready)
//
//  allocate: pick with link read, then pop; answered straight from pick if empty
//  free: low bound, high bound, slot index with push, ending early when
//    rejected; one shared adder does every bound check and address build
//  a new request is taken the cycle after the response transaction
//  rsp_o stalls simply hold the response; reset empties all lists at once
//
module per_cpu_page_allocator_core (
  input logic        clk_i,
  input logic        rst_ni,
  pca_req_if.sink    req_i,
  pca_rsp_if.source  rsp_o,
  pca_cfg_if.sink    cfg_i
);
  import pca_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PICK,
    S_POP,
    S_LO,
    S_HI,
    S_IDX,
    S_OUT
  } state_e;

  // page number of region_start rounded up to a page
  function automatic logic [PNUM_W-1:0] page_base(input logic [ADDR_W-1:0] start);
    return {1'b0, start[ADDR_W-1:PAGE_SHIFT]} + PNUM_W'(|start[PAGE_SHIFT-1:0]);
  endfunction

  localparam logic [PNUM_W-1:0] BASE_RST = page_base(REGION_START_RST);

  state_e               state_q;
  logic [CPU_W-1:0]     cpu_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [CPU_IDX_W-1:0] pick_q;
  logic [ADDR_W-1:0]    start_q;
  logic [ADDR_W-1:0]    stop_q;
  logic [PNUM_W-1:0]    base_q;
  rsp_t                 rsp_q;
  logic                 rsp_valid_q;
  logic [CPU_COUNT-1:0] nonempty_q;
  logic [SLOT_W-1:0]    head_q [CPU_COUNT];

  logic                 cpu_ok;
  logic [CPU_IDX_W-1:0] cpu_idx;
  logic                 pick_found;
  logic [CPU_IDX_W-1:0] pick_idx;
  logic [ALU_W-1:0]     alu_a;
  logic [ALU_W-1:0]     alu_b;
  logic                 alu_sub;
  logic [ALU_W-1:0]     alu_res;
  logic                 alu_borrow;
  logic                 idx_ok;
  logic [SLOT_W-1:0]    new_slot;
  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_addr;
  logic [SLOT_W-1:0]    ram_wdata;
  logic [SLOT_W-1:0]    ram_rdata;
  logic                 pop_last;
  rsp_t                 reject_rsp;

  // requesting cpu decode
  assign cpu_ok  = 32'(cpu_q) < 32'(CPU_COUNT);
  assign cpu_idx = CPU_IDX_W'(cpu_q);

  // round-robin pick: own list first, then the next non-empty one
  always_comb begin
    int unsigned cand;
    pick_found = 1'b0;
    pick_idx   = cpu_idx;
    for (int k = CPU_COUNT - 1; k >= 0; k--) begin
      cand = 32'(cpu_idx) + 32'(k);
      if (cand >= CPU_COUNT) begin
        cand = cand - CPU_COUNT;
      end
      if (nonempty_q[cand[CPU_IDX_W-1:0]]) begin
        pick_found = 1'b1;
        pick_idx   = cand[CPU_IDX_W-1:0];
      end
    end
  end

  // shared adder operand select
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    unique case (state_q)
      S_LO: begin
        alu_a = ALU_W'(addr_q);
        alu_b = ALU_W'(start_q);
      end
      S_HI: begin
        alu_a = ALU_W'(addr_q);
        alu_b = ALU_W'(stop_q);
      end
      S_IDX: begin
        alu_a = ALU_W'(addr_q[ADDR_W-1:PAGE_SHIFT]);
        alu_b = ALU_W'(base_q);
      end
      S_POP: begin
        alu_a   = ALU_W'(base_q);
        alu_b   = ALU_W'(slot_q);
        alu_sub = 1'b0;
      end
      default: ;
    endcase
  end

  assign alu_res    = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
  assign alu_borrow = alu_res[ALU_W-1];
  assign idx_ok     = alu_res < ALU_W'(PAGE_COUNT);
  assign new_slot   = alu_res[SLOT_W-1:0];
  assign pop_last   = ram_rdata == slot_q;
  assign reject_rsp = '{page_addr: '0, status: ST_REJECT};

  // link memory port: read the head in pick, write the link on push
  assign ram_we    = (state_q == S_IDX) && idx_ok;
  assign ram_addr  = (state_q == S_IDX) ? new_slot : head_q[pick_idx];
  assign ram_wdata = nonempty_q[cpu_idx] ? head_q[cpu_idx] : new_slot;

  pca_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (PAGE_COUNT)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // sequencer, registers and registered response
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cpu_q       <= '0;
      addr_q      <= '0;
      slot_q      <= '0;
      pick_q      <= '0;
      start_q     <= REGION_START_RST;
      stop_q      <= REGION_STOP_RST;
      base_q      <= BASE_RST;
      rsp_q       <= '0;
      rsp_valid_q <= 1'b0;
      nonempty_q  <= '0;
    end else begin
      // configuration writes
      if (cfg_i.valid) begin
        unique case (cfg_reg_e'(cfg_i.payload.index))
          REG_REGION_START: begin
            start_q <= cfg_i.payload.data;
            base_q  <= page_base(cfg_i.payload.data);
          end
          REG_REGION_STOP: stop_q <= cfg_i.payload.data;
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            cpu_q   <= req_i.payload.cpu;
            addr_q  <= req_i.payload.addr;
            state_q <= (req_i.payload.operation == OP_FREE) ? S_LO : S_PICK;
          end
        end
        S_PICK: begin
          if (cpu_ok && pick_found) begin
            pick_q  <= pick_idx;
            slot_q  <= head_q[pick_idx];
            state_q <= S_POP;
          end else begin
            rsp_q       <= '{page_addr: '0, status: ST_EMPTY};
            rsp_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end
        end
        S_POP: begin
          if (pop_last) begin
            nonempty_q[pick_q] <= 1'b0;
          end
          rsp_q.page_addr <= {alu_res[ADDR_W-PAGE_SHIFT-1:0], {PAGE_SHIFT{1'b0}}};
          rsp_q.status    <= ST_ALLOC;
          rsp_valid_q     <= 1'b1;
          state_q         <= S_OUT;
        end
        S_LO: begin
          if (!cpu_ok || (|addr_q[PAGE_SHIFT-1:0]) || alu_borrow) begin
            rsp_q       <= reject_rsp;
            rsp_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end else begin
            state_q <= S_HI;
          end
        end
        S_HI: begin
          if (!alu_borrow) begin
            rsp_q       <= reject_rsp;
            rsp_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end else begin
            state_q <= S_IDX;
          end
        end
        S_IDX: begin
          if (idx_ok) begin
            nonempty_q[cpu_idx] <= 1'b1;
            rsp_q               <= '{page_addr: '0, status: ST_FREED};
          end else begin
            rsp_q <= reject_rsp;
          end
          rsp_valid_q <= 1'b1;
          state_q     <= S_OUT;
        end
        S_OUT: begin
          if (rsp_o.ready) begin
            rsp_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // list heads, no reset: read only while the list is non-empty
  always_ff @(posedge clk_i) begin
    if ((state_q == S_POP) && !pop_last) begin
      head_q[pick_q] <= ram_rdata;
    end
    if (ram_we) begin
      head_q[cpu_idx] <= new_slot;
    end
  end

  // channel outputs
  assign req_i.ready   = (state_q == S_IDLE);
  assign cfg_i.ready   = 1'b1;
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  // response is only presented in the output state
  a_rsp_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> state_q == S_OUT)
    else $error("response valid outside output state");

  // no request taken while a response is pending
  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> !req_i.ready)
    else $error("request ready while response pending");

  // response transaction returns the sequencer to idle
  a_rsp_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.ready) |=> (state_q == S_IDLE && !rsp_valid_q))
    else $error("sequencer not idle after response transaction");

  // frees never return a page address
  a_free_zero_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_q.status == ST_FREED || rsp_q.status == ST_REJECT))
      |-> rsp_q.page_addr == '0)
    else $error("free response carries a page address");

  // a push always leaves its list non-empty
  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> nonempty_q[$past(cpu_idx)])
    else $error("list empty after push");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Randomized check of the per-cpu page allocator. Requests come from a queue
// through a valid/ready driver; every accepted request runs through a local
// free list predictor and each response is compared with the oldest answer.
// ----------------------------------------------------------------------------
module testbench;
  import pca_pkg::*;

  // quiet cycles after the last response before a register write or the end
  localparam int unsigned SETTLE_CYCLES = 8;
  // cycles without any transaction before the run is declared hung
  localparam int unsigned STALL_LIMIT   = 2000;

  logic clk_i;
  logic rst_ni;

  pca_req_if req_ch ();
  pca_rsp_if rsp_ch ();
  pca_cfg_if cfg_ch ();

  per_cpu_page_allocator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch),
    .cfg_i  (cfg_ch)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // predictor state: region registers and the per-cpu lifo lists
  logic [ADDR_W-1:0] region_lo;
  logic [ADDR_W-1:0] region_hi;
  logic [SLOT_W-1:0] next_slot [PAGE_COUNT];
  logic [SLOT_W-1:0] top_slot  [CPU_COUNT];
  bit                has_pages [CPU_COUNT];

  req_t              request_q [$];
  rsp_t              answer_q  [$];
  int unsigned       mismatches;
  longint unsigned   next_fresh;

  bit                req_taken;
  int unsigned       send_gap;
  int unsigned       hold_gap;
  bit                send_calm;
  bit                hold_calm;
  int unsigned       idle_cycles;

  // page address of slot zero: region start rounded up to a page
  function automatic longint unsigned page_base();
    longint unsigned lo;
    lo = 64'(region_lo);
    return ((lo + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
  endfunction

  // allocator answer for one request, updating the lists
  function automatic rsp_t predict_answer(input req_t r);
    longint unsigned base;
    longint unsigned a;
    longint unsigned idx;
    longint unsigned off;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] nxt;
    int unsigned pick;
    int unsigned i;
    bit found;
    rsp_t ans;
    ans.page_addr = '0;
    base = page_base();
    a = 64'(r.addr);
    if (r.operation == OP_FREE) begin
      ans.status = ST_REJECT;
      if (r.cpu < CPU_COUNT && a % PAGE_BYTES == 0 && a >= region_lo && a < region_hi) begin
        idx = (a - base) / PAGE_BYTES;
        if (idx < PAGE_COUNT) begin
          slot = idx[SLOT_W-1:0];
          next_slot[slot] = has_pages[r.cpu] ? top_slot[r.cpu] : slot;
          top_slot[r.cpu] = slot;
          has_pages[r.cpu] = 1'b1;
          ans.status = ST_FREED;
        end
      end
    end else begin
      ans.status = ST_EMPTY;
      if (r.cpu < CPU_COUNT) begin
        pick = 32'(r.cpu);
        found = has_pages[pick];
        i = (pick + 1) % CPU_COUNT;
        // steal from the next non-empty list going round
        while (!found && i != r.cpu) begin
          if (has_pages[i]) begin
            pick = i;
            found = 1'b1;
          end else begin
            i = (i + 1) % CPU_COUNT;
          end
        end
        if (found) begin
          slot = top_slot[pick];
          nxt = next_slot[slot];
          if (nxt == slot) begin
            has_pages[pick] = 1'b0;
          end else begin
            top_slot[pick] = nxt;
          end
          off = 64'(slot);
          ans.page_addr = 32'(base + off * PAGE_BYTES);
          ans.status = ST_ALLOC;
        end
      end
    end
    return ans;
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // free address: mostly pages of the region, the rest out of bounds or junk
  function automatic logic [ADDR_W-1:0] pick_free_addr();
    longint unsigned base;
    longint unsigned hi;
    longint unsigned n;
    longint unsigned p;
    int unsigned roll;
    base = page_base();
    hi = 64'(region_hi);
    n = (hi > base) ? (hi - base + PAGE_BYTES - 1) / PAGE_BYTES : 0;
    if (n > PAGE_COUNT) n = PAGE_COUNT;
    roll = $urandom_range(99, 0);
    if (n != 0 && roll < 75) begin
      if (roll < 55) begin
        p = next_fresh % n;
        next_fresh++;
      end else if (roll < 65) begin
        p = $urandom_range(int'(n - 1), 0);
      end else if (roll < 70) begin
        p = n - 1;
      end else begin
        // narrow window, double frees likely
        p = $urandom_range(int'((n < 4 ? n : 4) - 1), 0);
      end
      return 32'(base + p * PAGE_BYTES);
    end
    case (roll % 6)
      0: return $urandom();
      1: return 32'(base) + $urandom_range(PAGE_BYTES - 1, 1);
      2: return 32'(base - PAGE_BYTES);
      3: return 32'(base + n * PAGE_BYTES);
      4: return '0;
      default: return '1;
    endcase
  endfunction

  task automatic queue_request(input op_e op, input int unsigned cpu,
                               input logic [ADDR_W-1:0] addr);
    req_t r;
    r.operation = op;
    r.cpu = cpu[CPU_W-1:0];
    r.addr = addr;
    request_q.push_back(r);
  endtask

  // bursts that fill, drain or mix, sometimes on a pair of cpus only
  task automatic queue_random(input int unsigned count);
    int unsigned made;
    int unsigned len;
    int unsigned k;
    int unsigned mode;
    int unsigned focus;
    int unsigned free_pct;
    int unsigned cpu;
    bit narrow;
    made = 0;
    while (made < count) begin
      len = $urandom_range(30, 4);
      mode = $urandom_range(2, 0);
      focus = $urandom_range(CPU_COUNT - 1, 0);
      narrow = ($urandom_range(1, 0) != 0);
      free_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
      for (k = 0; k < len && made < count; k++) begin
        cpu = narrow ? (focus + $urandom_range(1, 0)) % CPU_COUNT
                     : $urandom_range(CPU_COUNT - 1, 0);
        if ($urandom_range(99, 0) < free_pct) begin
          queue_request(OP_FREE, cpu, pick_free_addr());
        end else begin
          queue_request(OP_ALLOC, cpu, $urandom());
        end
        made++;
      end
    end
  endtask

  // wait until every request is answered, then let the block settle
  task automatic wait_drained();
    do @(posedge clk_i);
    while (request_q.size() != 0 || req_ch.valid || answer_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one register write transaction
  task automatic write_reg(input cfg_reg_e idx, input logic [ADDR_W-1:0] val);
    @(negedge clk_i);
    cfg_ch.payload.index <= idx;
    cfg_ch.payload.data <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ch.ready);
    if (idx == REG_REGION_START) begin
      region_lo = val;
    end else begin
      region_hi = val;
    end
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // new region, then random traffic with a full drain halfway
  task automatic run_phase(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi,
                           input int unsigned count);
    wait_drained();
    write_reg(REG_REGION_START, lo);
    write_reg(REG_REGION_STOP, hi);
    next_fresh = 0;
    queue_random(count / 2);
    wait_drained();
    queue_random(count - count / 2);
  endtask

  // reset, stimulus and final verdict
  initial begin
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    region_lo = REGION_START_RST;
    region_hi = REGION_STOP_RST;
    for (int c = 0; c < CPU_COUNT; c++) begin
      has_pages[c] = 1'b0;
      top_slot[c] = '0;
    end
    mismatches = 0;
    next_fresh = 0;
    req_taken = 1'b0;
    send_gap = 0;
    hold_gap = 0;
    send_calm = 1'b0;
    hold_calm = 1'b0;
    idle_cycles = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: bounds, first and last slot, lifo order, stealing, double free
    queue_request(OP_ALLOC, 0, 32'h0000_0000);
    queue_request(OP_FREE,  0, 32'h8000_0000);
    queue_request(OP_FREE,  7, 32'h87FF_F000);
    queue_request(OP_FREE,  0, 32'h8000_0001);
    queue_request(OP_FREE,  0, 32'h7FFF_F000);
    queue_request(OP_FREE,  0, 32'h8800_0000);
    queue_request(OP_FREE,  5, 32'hFFFF_FFFF);
    queue_request(OP_FREE,  5, 32'h0000_0000);
    queue_request(OP_FREE,  0, 32'h8000_1000);
    queue_request(OP_ALLOC, 0, 32'hFFFF_FFFF);
    queue_request(OP_ALLOC, 0, 32'h0000_0000);
    queue_request(OP_ALLOC, 0, 32'h0000_0000);
    queue_request(OP_ALLOC, 3, 32'h0000_0000);
    queue_request(OP_FREE,  1, 32'h8000_5000);
    queue_request(OP_ALLOC, 2, 32'h0000_0000);
    queue_request(OP_FREE,  4, 32'h8000_2000);
    queue_request(OP_FREE,  4, 32'h8000_2000);
    queue_request(OP_ALLOC, 4, 32'h0000_0000);
    queue_request(OP_ALLOC, 4, 32'h0000_0000);
    queue_request(OP_FREE,  6, 32'h8000_2000);
    queue_request(OP_FREE,  6, 32'h8000_3000);
    queue_request(OP_FREE,  6, 32'h8000_2000);
    queue_request(OP_ALLOC, 6, 32'h0000_0000);
    queue_request(OP_ALLOC, 6, 32'h0000_0000);
    queue_request(OP_ALLOC, 6, 32'h0000_0000);
    queue_random(150);

    // region settings: unaligned start, full space, top of memory, base past
    // the address space, empty region, slot limit, inverted bounds
    run_phase(32'h0000_0123, 32'h0004_0000, 220);
    run_phase(32'h0000_0000, 32'hFFFF_FFFF, 220);
    run_phase(32'hFFFF_8000, 32'hFFFF_FFFF, 160);
    run_phase(32'hFFFF_F001, 32'hFFFF_FFFF, 80);
    run_phase(32'h4000_0000, 32'h4000_0000, 50);
    run_phase(32'h1234_5000, 32'h2000_0000, 220);
    run_phase(32'hFFFF_FFFF, 32'h0000_0000, 40);

    wait_drained();
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("** per_cpu_page_allocator_core: PASSED **");
    end else begin
      $display("** per_cpu_page_allocator_core: FAILED **");
    end
    $finish;
  end

  // request driver: holds each transaction until accepted, random gaps after
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_ch.valid || req_taken) begin
        req_taken = 1'b0;
        if (send_gap != 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          req_ch.payload <= request_q.pop_front();
          req_ch.valid <= 1'b1;
          if ($urandom_range(63, 0) == 0) send_calm = !send_calm;
          send_gap = send_calm ? 0 : idle_len();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response sink: random stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_gap != 0) begin
        hold_gap--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if ($urandom_range(127, 0) == 0) hold_calm = !hold_calm;
        if (!hold_calm && $urandom_range(3, 0) == 0) hold_gap = idle_len();
      end
    end
  end

  // monitor: predict on request transactions, check response transactions
  always @(posedge clk_i) begin : monitor
    rsp_t want;
    rsp_t got;
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) begin
        answer_q.push_back(predict_answer(req_ch.payload));
        req_taken = 1'b1;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.payload;
        if (answer_q.size() == 0) begin
          $display("%0t: response with none pending: page_addr %h status %0d",
                   $time, got.page_addr, got.status);
          mismatches++;
        end else begin
          want = answer_q.pop_front();
          if (got.page_addr !== want.page_addr) begin
            $display("%0t: page_addr expected %h actual %h",
                     $time, want.page_addr, got.page_addr);
            mismatches++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, got.status);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("** per_cpu_page_allocator_core: FAILED **");
      $finish;
    end
  end

endmodule
